### sv/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants
// Field widths, register codes, controller states and the command and
// status groups exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

	localparam int MAX_DEGREE_DEF = 15;

	localparam int COEF_W     = 48;
	localparam int X_W        = 24;
	localparam int RECIP_W    = 48;
	localparam int RECIP_HW   = 24;
	localparam int DEG_W      = 4;
	localparam int IDX_IN_W   = 4;
	localparam int T_W        = 32;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 64;
	localparam int TERM_W     = 50;
	localparam int FULL_W     = 80;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	localparam logic [RECIP_W-1:0] RECIP_RESET = 48'h0001_0000_0000;
	localparam logic [DEG_W-1:0]   DEG_RESET   = 4'd10;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TWO_OVER_MODULUS = 1'b0,
		REG_DEGREE_IN_USE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RL,
		ST_SCALE,
		ST_TA,
		ST_TB,
		ST_D1,
		ST_D2,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_coef;
		logic start;
		logic mul_rl;
		logic scale;
		logic step_a;
		logic step_b;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_term;
		logic deg_zero;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

### sv/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl: sequencing controller
// Accepts requests, walks the scaling steps, two steps per series term and
// the accumulate drain, then hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cse_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             op,
	output logic                  in_stall,
	input  wire cse_pkg::status_t status,
	output cse_pkg::cmd_t         cmd
);

	cse_pkg::state_t state_q;
	cse_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cse_pkg::ST_IDLE: begin
				if (in_valid && (op == cse_pkg::OP_EVAL)) begin
					state_d = cse_pkg::ST_RL;
				end
			end
			cse_pkg::ST_RL:    state_d = cse_pkg::ST_SCALE;
			cse_pkg::ST_SCALE: begin
				state_d = status.deg_zero ? cse_pkg::ST_FIN : cse_pkg::ST_TA;
			end
			cse_pkg::ST_TA:    state_d = cse_pkg::ST_TB;
			cse_pkg::ST_TB: begin
				state_d = status.last_term ? cse_pkg::ST_D1 : cse_pkg::ST_TA;
			end
			cse_pkg::ST_D1:    state_d = cse_pkg::ST_D2;
			cse_pkg::ST_D2:    state_d = cse_pkg::ST_FIN;
			cse_pkg::ST_FIN: begin
				if (status.out_free) begin
					state_d = cse_pkg::ST_IDLE;
				end
			end
			default:           state_d = cse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			cse_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_coef = in_valid && (op == cse_pkg::OP_LOAD);
				cmd.start     = in_valid && (op == cse_pkg::OP_EVAL);
			end
			cse_pkg::ST_RL:    cmd.mul_rl   = 1'b1;
			cse_pkg::ST_SCALE: cmd.scale    = 1'b1;
			cse_pkg::ST_TA:    cmd.step_a   = 1'b1;
			cse_pkg::ST_TB:    cmd.step_b   = 1'b1;
			cse_pkg::ST_D1:    cmd          = '0;
			cse_pkg::ST_D2:    cmd          = '0;
			cse_pkg::ST_FIN:   cmd.out_load = status.out_free;
			default:           cmd          = '0;
		endcase
	end

endmodule

`default_nettype wire

### sv/cse_datapath.sv
// ----------------------------------------------------------------------------
// cse_datapath: coefficient store, multipliers and accumulator
// Scales the point into Q2.30, runs the Chebyshev recurrence on one
// multiplier and the coefficient products on another, accumulates exactly
// and saturates into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cse_datapath #(
	parameter int MAX_DEGREE = cse_pkg::MAX_DEGREE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cse_pkg::cmd_t                       cmd,
	output cse_pkg::status_t                         status,
	input  wire logic        [cse_pkg::IDX_IN_W-1:0] coeff_index,
	input  wire logic signed [cse_pkg::COEF_W-1:0]   coeff_value,
	input  wire logic        [cse_pkg::X_W-1:0]      x_value,
	input  wire logic                                cfg_write,
	input  wire logic        [cse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [cse_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [cse_pkg::COEF_W-1:0]   approx_value,
	output logic                                     saturated
);

	localparam int DEPTH = MAX_DEGREE + 1;
	localparam int IW    = $clog2(DEPTH);
	localparam int SW    = cse_pkg::TERM_W + $clog2(DEPTH);
	localparam int CW    = cse_pkg::COEF_W;
	localparam int TW    = cse_pkg::T_W;
	localparam int MW    = cse_pkg::MUL_W;
	localparam int PW    = cse_pkg::PROD_W;
	localparam int XW    = cse_pkg::X_W;
	localparam int HW    = cse_pkg::RECIP_HW;
	localparam int FW    = cse_pkg::FULL_W;
	localparam int UW    = 56;

	localparam logic [UW-1:0]        S_LIMIT = UW'(64'd3221225471);
	localparam logic signed [TW-1:0] T_MAX   = 32'sh7fff_ffff;
	localparam logic signed [TW-1:0] T_MIN   = 32'sh8000_0000;
	localparam logic signed [TW-1:0] Q30_ONE = 32'sh4000_0000;

	logic [cse_pkg::RECIP_W-1:0] recip_q;
	logic [cse_pkg::DEG_W-1:0]   deg_q;
	logic [IW-1:0]               deg_eff;

	logic signed [CW-1:0] coef_mem_q [DEPTH];
	logic [IW-1:0]        rd_idx;
	logic signed [CW-1:0] coef;

	logic [XW-1:0]        x_q;
	logic [PW-1:0]        uhi_q;
	logic signed [TW-1:0] s_q;
	logic signed [TW-1:0] t_cur_q;
	logic signed [TW-1:0] t_prev_q;
	logic [IW-1:0]        n_q;

	logic signed [MW-1:0]   ma;
	logic signed [MW-1:0]   mb;
	logic signed [2*MW-1:0] mp;
	logic signed [PW-1:0]   prodc_q;
	logic signed [PW-1:0]   ph_q;
	logic signed [PW-1:0]   rp;
	logic signed [PW-1:0]   prodr_q;

	logic [UW-1:0]        u;
	logic [32:0]          s_diff;
	logic signed [TW-1:0] s_new;

	logic signed [PW-1:0] r_full;
	logic signed [35:0]   t_diff;
	logic signed [TW-1:0] t_next;

	logic signed [FW-1:0]               full;
	logic                               pair_v_q;
	logic signed [cse_pkg::TERM_W-1:0]  term_s1;
	logic                               term_v_s1;
	logic signed [SW-1:0]               sum_q;

	logic                 sat_hi;
	logic                 sat_lo;
	logic signed [CW-1:0] out_val;
	logic                 out_valid_q;
	logic signed [CW-1:0] approx_q;
	logic                 sat_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= cse_pkg::RECIP_RESET;
			deg_q   <= cse_pkg::DEG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cse_pkg::REG_TWO_OVER_MODULUS: recip_q <= cfg_data[cse_pkg::RECIP_W-1:0];
				cse_pkg::REG_DEGREE_IN_USE:    deg_q   <= cfg_data[cse_pkg::DEG_W-1:0];
				default:                       deg_q   <= deg_q;
			endcase
		end
	end

	assign deg_eff = (32'(deg_q) > MAX_DEGREE) ? IW'(MAX_DEGREE) : IW'(deg_q);

	// coefficient store
	always_ff @(posedge clk) begin
		if (cmd.load_coef && (32'(coeff_index) <= MAX_DEGREE)) begin
			coef_mem_q[IW'(coeff_index)] <= coeff_value;
		end
	end

	assign rd_idx = cmd.scale ? '0 : n_q;
	assign coef   = coef_mem_q[rd_idx];

	// coefficient and scaling multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		priority if (cmd.start) begin
			ma = MW'(x_value);
			mb = MW'(recip_q[cse_pkg::RECIP_W-1:HW]);
		end else if (cmd.mul_rl) begin
			ma = MW'(x_q);
			mb = MW'(recip_q[HW-1:0]);
		end else if (cmd.step_a) begin
			ma = MW'(signed'(coef[CW-1:16]));
			mb = MW'(t_cur_q);
		end else if (cmd.step_b) begin
			ma = MW'(coef[15:0]);
			mb = MW'(t_cur_q);
		end else begin
			ma = '0;
			mb = '0;
		end
	end

	assign mp = ma * mb;
	assign rp = PW'(s_q) * PW'(t_cur_q);

	// point scaling into Q2.30
	assign u      = (UW'(uhi_q[47:0]) << 7) + UW'((prodc_q[47:0] + 48'd65536) >> 17);
	assign s_diff = {1'b0, u[31:0]} - 33'h0_4000_0000;
	assign s_new  = (u > S_LIMIT) ? T_MAX : signed'(s_diff[TW-1:0]);

	// recurrence update
	assign r_full = (prodr_q + (64'sd1 <<< 28)) >>> 29;
	assign t_diff = 36'(signed'(r_full[34:0])) - 36'(t_prev_q);
	always_comb begin
		if (t_diff[35:31] == 5'b00000 || t_diff[35:31] == 5'b11111) begin
			t_next = t_diff[TW-1:0];
		end else if (t_diff[35]) begin
			t_next = T_MIN;
		end else begin
			t_next = T_MAX;
		end
	end

	// term rounding
	assign full = (FW'(ph_q) <<< 16) + FW'(prodc_q) + (80'sd1 <<< 29);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x_value;
		end
		if (cmd.start || cmd.mul_rl || cmd.step_a || cmd.step_b) begin
			prodc_q <= mp[PW-1:0];
		end
		if (cmd.mul_rl) begin
			uhi_q <= prodc_q;
		end
		if (cmd.step_a) begin
			prodr_q <= rp;
		end
		if (cmd.step_b) begin
			ph_q     <= prodc_q;
			t_prev_q <= t_cur_q;
			t_cur_q  <= t_next;
		end
		if (cmd.scale) begin
			s_q      <= s_new;
			t_cur_q  <= s_new;
			t_prev_q <= Q30_ONE;
			sum_q    <= SW'(coef) >>> 1;
		end else if (term_v_s1) begin
			sum_q <= sum_q + SW'(term_s1);
		end
		if (pair_v_q) begin
			term_s1 <= full[FW-1:30];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			pair_v_q  <= 1'b0;
			term_v_s1 <= 1'b0;
		end else begin
			pair_v_q  <= cmd.step_b;
			term_v_s1 <= pair_v_q;
			if (cmd.scale) begin
				n_q <= IW'(1);
			end else if (cmd.step_b) begin
				n_q <= n_q + IW'(1);
			end
		end
	end

	// saturation and output register
	assign sat_hi = !sum_q[SW-1] && (sum_q[SW-1:CW-1] != '0);
	assign sat_lo = sum_q[SW-1] && (sum_q[SW-1:CW-1] != '1);

	always_comb begin
		if (sat_hi) begin
			out_val = {1'b0, {(CW-1){1'b1}}};
		end else if (sat_lo) begin
			out_val = {1'b1, {(CW-1){1'b0}}};
		end else begin
			out_val = sum_q[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			approx_q <= out_val;
			sat_q    <= sat_hi || sat_lo;
		end
	end

	assign out_valid    = out_valid_q;
	assign approx_value = approx_q;
	assign saturated    = sat_q;

	assign status.last_term = (n_q == deg_eff);
	assign status.deg_zero  = (deg_eff == '0);
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

### sv/chebyshev_series_evaluator_top.sv
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator_top: truncated Chebyshev series evaluator
// Load requests write the coefficient store when accepted. An evaluate request runs
// the scaling steps, then two steps per term, D = min(degree_in_use, MAX_DEGREE),
// through the recurrence multiplier and the split coefficient product, then the
// drain (terms and drain are skipped when D is zero), and raises out_valid. A new
// request stalls until the result enters the output register. Reset clears the controller
// and out_valid and restores the configuration defaults; the coefficient store is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chebyshev_series_evaluator_top #(
	parameter int MAX_DEGREE = cse_pkg::MAX_DEGREE_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 op,
	input  wire logic        [cse_pkg::IDX_IN_W-1:0]  coeff_index,
	input  wire logic signed [cse_pkg::COEF_W-1:0]    coeff_value,
	input  wire logic        [cse_pkg::X_W-1:0]       x_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [cse_pkg::COEF_W-1:0]    approx_value,
	output logic                                      saturated,
	input  wire logic                                 cfg_write,
	input  wire logic        [cse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [cse_pkg::CFG_DATA_W-1:0] cfg_data
);

	cse_pkg::cmd_t    cmd;
	cse_pkg::status_t status;

	cse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cse_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.coeff_index  (coeff_index),
		.coeff_value  (coeff_value),
		.x_value      (x_value),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.approx_value (approx_value),
		.saturated    (saturated)
	);

endmodule

`default_nettype wire
